### rtl/core/arena_bump_allocator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the arena bump allocator
// Clocked concurrent assertion forms used by the checker file aba_checker.
// ---------------------------------------------------------------------------
`ifndef ARENA_BUMP_ALLOCATOR_TOP_ASSERT_SVH
`define ARENA_BUMP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define ABA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ABA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/aba_pkg.sv
// ---------------------------------------------------------------------------
// aba_pkg
// Widths, codes, header layout and state encoding of the arena allocator.
// ---------------------------------------------------------------------------
package aba_pkg;

	localparam int ARENA_BYTES  = 65536;
	localparam int ALIGN        = 16;      // power of two
	localparam int HEADER_BYTES = 16;

	localparam int ALIGN_LG = $clog2(ALIGN);
	localparam int UNITS    = ARENA_BYTES / ALIGN;
	localparam int SLOT_W   = $clog2(UNITS);

	localparam int ADDR_W = 17;                 // field width of addresses and sizes
	localparam int CALC_W = ADDR_W + 2;         // room for top + header + rounded size
	localparam int LEN_W  = SLOT_W + 1;         // block length in units, up to UNITS
	localparam int RND_W  = ADDR_W + 1 - ALIGN_LG;  // rounded request in units
	localparam int HDR_W  = LEN_W + 1;

	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;
	localparam int CFG_IDX_W = 1;

	// input request packing, lowest bit first
	localparam int IN_ACT_LSB  = 0;
	localparam int IN_SIZE_LSB = IN_ACT_LSB + ACT_W;
	localparam int IN_ADDR_LSB = IN_SIZE_LSB + ADDR_W;
	localparam int IN_BITS     = IN_ADDR_LSB + ADDR_W;
	localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;

	// result packing, lowest bit first
	localparam int OUT_RES_LSB  = 0;
	localparam int OUT_STAT_LSB = OUT_RES_LSB + ADDR_W;
	localparam int OUT_COPY_LSB = OUT_STAT_LSB + STAT_W;
	localparam int OUT_BITS     = OUT_COPY_LSB + ADDR_W;
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REALLOC = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SAVE    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RESTORE = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OOM   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_AGAIN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ARENA_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFFSET = 1'b1;

	localparam logic [ADDR_W-1:0] ARENA_SIZE_RST   = 17'd65536;
	localparam logic [ADDR_W-1:0] FIRST_OFFSET_RST = 17'd0;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             freed;
	} hdr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FREE
	} state_t;

endpackage

### rtl/core/arena_bump_allocator_top.sv
// A result is loaded into the output register in ST_EXEC, once that register is free.
// No request is taken outside ST_IDLE; a realloc that moves its block also passes ST_FREE,
// since the new header and the old one's freed mark share the header RAM's single write port.
// Reset: top loads first_offset (0), arena_size loads 65536, the output empties; the header
// RAM is not cleared and holds nothing meaningful until written.
// ---------------------------------------------------------------------------
// arena_bump_allocator_top
// Bump allocator with top pointer rollback; headers live in a synchronous RAM.
// ---------------------------------------------------------------------------
module arena_bump_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [aba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aba_pkg::ADDR_W-1:0]   cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [aba_pkg::IN_W-1:0]     s_tdata,  // action, request_size, block_address
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [aba_pkg::OUT_W-1:0]    m_tdata   // result_address, status, copy_length
);
	import aba_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0] arena_q;
	logic [ADDR_W-1:0] top_q, top_d;

	logic [ACT_W-1:0]  act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [RND_W-1:0]  rnd_q;
	logic [SLOT_W-1:0] slot_q;
	logic              slot_ok_q;
	logic [LEN_W-1:0]  eff_len_q, eff_len_d;

	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// request decode
	logic              in_acc;
	logic [ACT_W-1:0]  in_act;
	logic [ADDR_W-1:0] in_size;
	logic [ADDR_W-1:0] in_addr;
	logic [ADDR_W:0]   in_size_up;
	logic [ADDR_W-1:0] in_addr_off;
	logic              in_slot_ok;
	logic [SLOT_W-1:0] in_slot;

	assign in_acc  = s_tvalid && s_tready;
	assign in_act  = s_tdata[IN_ACT_LSB +: ACT_W];
	assign in_size = s_tdata[IN_SIZE_LSB +: ADDR_W];
	assign in_addr = s_tdata[IN_ADDR_LSB +: ADDR_W];

	assign in_size_up  = {1'b0, in_size} + (ADDR_W+1)'(ALIGN - 1);
	assign in_addr_off = in_addr - ADDR_W'(HEADER_BYTES);
	assign in_slot     = in_addr_off[ALIGN_LG +: SLOT_W];
	assign in_slot_ok  = (in_addr >= ADDR_W'(HEADER_BYTES))
		&& ((in_addr_off >> (ALIGN_LG + SLOT_W)) == '0);

	// header RAM
	hdr_t              rd_hdr;
	logic [HDR_W-1:0]  mem_rdata;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	hdr_t              mem_wdata;

	aba_ram #(
		.WIDTH (HDR_W),
		.DEPTH (UNITS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_acc),
		.raddr (in_slot),
		.rdata (mem_rdata)
	);

	assign rd_hdr = hdr_t'(mem_rdata);

	// datapath
	logic [CALC_W-1:0] top_w, addr_w, limit_w, rnd_bytes;
	logic [CALC_W-1:0] a_data, a_new, ip_new, old_end, fr_end;
	logic              a_fail, ip_fail, at_top, fr_hit;
	logic [SLOT_W-1:0] alloc_slot;
	logic              alloc_slot_ok, same_slot;
	logic [LEN_W-1:0]  eff_len, fr_len;
	logic [ADDR_W-1:0] addr_less;
	logic              out_free, do_alloc;

	assign top_w     = CALC_W'(top_q);
	assign addr_w    = CALC_W'(addr_q);
	assign limit_w   = (arena_q < ADDR_W'(ARENA_BYTES)) ? CALC_W'(arena_q)
		: CALC_W'(ARENA_BYTES);
	assign rnd_bytes = CALC_W'({rnd_q, {ALIGN_LG{1'b0}}});

	assign a_data  = top_w + CALC_W'(HEADER_BYTES);
	assign a_new   = a_data + rnd_bytes;
	assign a_fail  = a_new > limit_w;
	assign ip_new  = addr_w + rnd_bytes;
	assign ip_fail = ip_new > limit_w;
	assign old_end = addr_w + CALC_W'({rd_hdr.len, {ALIGN_LG{1'b0}}});
	assign at_top  = old_end == top_w;

	assign alloc_slot    = top_q[ALIGN_LG +: SLOT_W];
	assign alloc_slot_ok = (top_q >> (ALIGN_LG + SLOT_W)) == '0;
	// a moved block whose old header shares the new header's slot sees the new length
	assign same_slot     = alloc_slot_ok && (alloc_slot == slot_q);
	assign eff_len       = same_slot ? rnd_q[LEN_W-1:0] : rd_hdr.len;

	assign fr_len    = (state_q == ST_FREE) ? eff_len_q : rd_hdr.len;
	assign fr_end    = addr_w + CALC_W'({fr_len, {ALIGN_LG{1'b0}}});
	assign fr_hit    = fr_end == top_w;
	assign addr_less = addr_q - ADDR_W'(HEADER_BYTES);

	assign out_free = !m_tvalid_q || m_tready;
	assign do_alloc = (act_q == ACT_ALLOC) || ((act_q == ACT_REALLOC) && !slot_ok_q);

	logic              out_load;
	logic [ADDR_W-1:0] res;
	logic [STAT_W-1:0] stat;
	logic [ADDR_W-1:0] copy;

	always_comb begin
		state_d   = state_q;
		top_d     = top_q;
		eff_len_d = eff_len_q;
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '{len: rd_hdr.len, freed: 1'b1};
		out_load  = 1'b0;
		res       = '0;
		stat      = STAT_OK;
		copy      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					priority if (do_alloc) begin
						if (a_fail) begin
							stat = STAT_OOM;
						end else begin
							mem_we    = alloc_slot_ok;
							mem_waddr = alloc_slot;
							mem_wdata = '{len: rnd_q[LEN_W-1:0], freed: 1'b0};
							top_d     = a_new[ADDR_W-1:0];
							res       = a_data[ADDR_W-1:0];
						end
					end else if (act_q == ACT_FREE) begin
						if (slot_ok_q) begin
							mem_we = 1'b1;
							stat   = rd_hdr.freed ? STAT_AGAIN : STAT_OK;
							if (fr_hit) begin
								top_d = addr_less;
							end
						end
					end else if (act_q == ACT_REALLOC) begin
						if (at_top) begin
							// resize in place
							if (ip_fail) begin
								stat = STAT_OOM;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = '{len: rnd_q[LEN_W-1:0], freed: rd_hdr.freed};
								top_d     = ip_new[ADDR_W-1:0];
								res       = addr_q;
								stat      = rd_hdr.freed ? STAT_AGAIN : STAT_OK;
							end
						end else if (a_fail) begin
							stat = STAT_OOM;
						end else begin
							// place the new header now, mark the old block freed next cycle
							mem_we    = alloc_slot_ok;
							mem_waddr = alloc_slot;
							mem_wdata = '{len: rnd_q[LEN_W-1:0], freed: 1'b0};
							top_d     = a_new[ADDR_W-1:0];
							res       = a_data[ADDR_W-1:0];
							copy      = ADDR_W'({eff_len, {ALIGN_LG{1'b0}}});
							stat      = rd_hdr.freed ? STAT_AGAIN : STAT_OK;
							eff_len_d = eff_len;
							state_d   = ST_FREE;
						end
					end else if (act_q == ACT_SAVE) begin
						res = top_q;
					end else if (act_q == ACT_RESTORE) begin
						top_d = addr_q;
					end else begin
						res = '0;
					end
				end
			end
			ST_FREE: begin
				mem_we    = 1'b1;
				mem_wdata = '{len: eff_len_q, freed: 1'b1};
				if (fr_hit) begin
					top_d = addr_less;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			arena_q    <= ARENA_SIZE_RST;
			top_q      <= FIRST_OFFSET_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen && (cfg_index == REG_FIRST_OFFSET)) begin
				top_q <= cfg_wdata;
			end else begin
				top_q <= top_d;
			end
			if (cfg_wen && (cfg_index == REG_ARENA_SIZE)) begin
				arena_q <= cfg_wdata;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q     <= in_act;
			addr_q    <= in_addr;
			rnd_q     <= in_size_up[ADDR_W:ALIGN_LG];
			slot_q    <= in_slot;
			slot_ok_q <= in_slot_ok;
		end
		eff_len_q <= eff_len_d;
		if (out_load) begin
			m_tdata_q <= OUT_W'({copy, stat, res});
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### rtl/core/aba_ram.sv
// ---------------------------------------------------------------------------
// aba_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module aba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/aba_checker.sv
// ---------------------------------------------------------------------------
// aba_checker
// Port-level checks of the arena allocator, bound to its top level.
// ---------------------------------------------------------------------------
`include "arena_bump_allocator_top_assert.svh"

module aba_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [aba_pkg::OUT_W-1:0] m_tdata
);
	import aba_pkg::*;

	logic [STAT_W-1:0] stat;
	logic [ADDR_W-1:0] res;
	logic [ADDR_W-1:0] copy;

	assign stat = m_tdata[OUT_STAT_LSB +: STAT_W];
	assign res  = m_tdata[OUT_RES_LSB +: ADDR_W];
	assign copy = m_tdata[OUT_COPY_LSB +: ADDR_W];

	// a stalled result holds
	`ABA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
	// a taken request keeps the block busy for its header access
	`ABA_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while header access pending")
	`ABA_ASSERT_NOW(a_stat_code, m_tvalid, stat == STAT_OK || stat == STAT_OOM || stat == STAT_AGAIN, "status code out of range")
	// a failed request returns no address and nothing to copy
	`ABA_ASSERT_NOW(a_oom_empty, m_tvalid && stat == STAT_OOM, res == '0 && copy == '0, "out-of-memory result carries data")

endmodule

bind arena_bump_allocator_top aba_checker u_aba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Arena bump allocator: directed and random alloc, free, realloc, save and
// restore requests under random gaps and back-pressure on both streams; every
// reply is checked field by field against a mirror of the top pointer and
// the block headers.
// ---------------------------------------------------------------------------
module tb;
	import aba_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_SIZE    = 65536;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] copy;
	} reply_t;

	class alloc_scoreboard;
		int unsigned arena_size;
		int unsigned first_offset;
		int unsigned top;
		int unsigned blk_units[UNITS];
		bit          freed[UNITS];
		bit          written[UNITS];
		int unsigned handed_out[$];
		int unsigned saved_tops[$];
		reply_t      replies_due[$];
		int          errors;

		function new();
			arena_size = ARENA_SIZE_RST;
			first_offset = FIRST_OFFSET_RST;
			top = FIRST_OFFSET_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
			if (idx == REG_ARENA_SIZE) begin
				arena_size = val;
			end else begin
				first_offset = val;
				top = val;
			end
		endfunction

		function int unsigned bound();
			return (arena_size < ARENA_BYTES) ? arena_size : ARENA_BYTES;
		endfunction

		function int unsigned round_up(int unsigned n);
			return ((n + ALIGN - 1) / ALIGN) * ALIGN;
		endfunction

		// header slot of a data address, -1 when it has none
		function int slot_of(int unsigned a);
			if (a < HEADER_BYTES) begin
				return -1;
			end
			if ((a - HEADER_BYTES) / ALIGN >= UNITS) begin
				return -1;
			end
			return (a - HEADER_BYTES) / ALIGN;
		endfunction

		function int unsigned bump_alloc(int unsigned size);
			int unsigned rounded;
			int unsigned data;
			int unsigned new_top;
			rounded = round_up(size);
			data = top + HEADER_BYTES;
			new_top = data + rounded;
			if (new_top > bound()) begin
				return 0;
			end
			if (top / ALIGN < UNITS) begin
				blk_units[top / ALIGN] = rounded / ALIGN;
				freed[top / ALIGN] = 1'b0;
				written[top / ALIGN] = 1'b1;
			end
			top = new_top;
			return data;
		endfunction

		// mark freed, roll top back when the block ends there
		function bit drop_block(int unsigned a, int idx);
			bit again;
			again = freed[idx];
			freed[idx] = 1'b1;
			if (a + blk_units[idx] * ALIGN == top) begin
				top = a - HEADER_BYTES;
			end
			return again;
		endfunction

		function void keep_handed_out(int unsigned a);
			if (a != 0) begin
				handed_out.push_back(a);
				if (handed_out.size() > 128) begin
					void'(handed_out.pop_front());
				end
			end
		endfunction

		function void note_request(logic [ACT_W-1:0] act, int unsigned size, int unsigned addr);
			reply_t      r;
			int          idx;
			int unsigned rounded;
			int unsigned old_len;
			int unsigned fresh;
			int unsigned new_top;
			bit          was_freed;
			r.addr = '0;
			r.status = STAT_OK;
			r.copy = '0;
			case (act)
				ACT_ALLOC: begin
					fresh = bump_alloc(size);
					keep_handed_out(fresh);
					r.addr = ADDR_W'(fresh);
					r.status = (fresh != 0) ? STAT_OK : STAT_OOM;
				end
				ACT_FREE: begin
					idx = slot_of(addr);
					if (idx >= 0) begin
						if (drop_block(addr, idx)) begin
							r.status = STAT_AGAIN;
						end
					end
				end
				ACT_REALLOC: begin
					idx = slot_of(addr);
					if (idx < 0) begin
						fresh = bump_alloc(size);
						keep_handed_out(fresh);
						r.addr = ADDR_W'(fresh);
						r.status = (fresh != 0) ? STAT_OK : STAT_OOM;
					end else begin
						rounded = round_up(size);
						was_freed = freed[idx];
						old_len = blk_units[idx] * ALIGN;
						if (addr + old_len == top) begin
							// resize in place
							new_top = addr + rounded;
							if (new_top > bound()) begin
								r.status = STAT_OOM;
							end else begin
								blk_units[idx] = rounded / ALIGN;
								top = new_top;
								r.addr = ADDR_W'(addr);
								r.status = was_freed ? STAT_AGAIN : STAT_OK;
							end
						end else begin
							// move: new block first, then old length, then free
							fresh = bump_alloc(rounded);
							if (fresh == 0) begin
								r.status = STAT_OOM;
							end else begin
								r.copy = ADDR_W'(blk_units[idx] * ALIGN);
								void'(drop_block(addr, idx));
								keep_handed_out(fresh);
								r.addr = ADDR_W'(fresh);
								r.status = was_freed ? STAT_AGAIN : STAT_OK;
							end
						end
					end
				end
				ACT_SAVE: begin
					r.addr = ADDR_W'(top);
					saved_tops.push_back(top);
					if (saved_tops.size() > 32) begin
						void'(saved_tops.pop_front());
					end
				end
				ACT_RESTORE: begin
					top = addr;
				end
				default: begin
				end
			endcase
			replies_due.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("%0t mismatch: %s", $time, msg);
			end
		endtask

		task check_reply(logic [OUT_W-1:0] d);
			reply_t            want;
			logic [ADDR_W-1:0] got_addr;
			logic [STAT_W-1:0] got_status;
			logic [ADDR_W-1:0] got_copy;
			got_addr = d[OUT_RES_LSB +: ADDR_W];
			got_status = d[OUT_STAT_LSB +: STAT_W];
			got_copy = d[OUT_COPY_LSB +: ADDR_W];
			if (replies_due.size() == 0) begin
				report($sformatf("reply %h with no request outstanding", d));
				return;
			end
			want = replies_due.pop_front();
			if (got_addr !== want.addr) begin
				report($sformatf("result_address got %h want %h", got_addr, want.addr));
			end
			if (got_status !== want.status) begin
				report($sformatf("status got %h want %h", got_status, want.status));
			end
			if (got_copy !== want.copy) begin
				report($sformatf("copy_length got %h want %h", got_copy, want.copy));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;

	alloc_scoreboard sb = new();

	bit quiet = 1'b0;
	bit want_hold = 1'b0;
	int hold_left = 0;
	int rx_wait = 0;
	int stalled_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	arena_bump_allocator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	function automatic int gap_len();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 60);
	endfunction

	// receive side: check, then pick the next stall
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_reply(m_tdata);
		end
		if (want_hold) begin
			want_hold = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_wait = gap_len();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stalled_cycles = 0;
		end else begin
			stalled_cycles++;
		end
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic offer_request(logic [ACT_W-1:0] act, int unsigned size, int unsigned addr);
		logic [IN_W-1:0] word;
		int              gap;
		word = '0;
		word[IN_ACT_LSB +: ACT_W] = act;
		word[IN_SIZE_LSB +: ADDR_W] = ADDR_W'(size);
		word[IN_ADDR_LSB +: ADDR_W] = ADDR_W'(addr);
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sb.note_request(act, size, addr);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.replies_due.size() != 0) begin
			@(posedge clk);
		end
		// let a moving realloc finish its free
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= ADDR_W'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic int unsigned pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return $urandom_range(0, 64);
		end
		if (r < 88) begin
			return $urandom_range(0, 1024);
		end
		if (r < 98) begin
			return $urandom_range(0, 16384);
		end
		if (r < 99) begin
			return MAX_SIZE;
		end
		return $urandom_range(0, MAX_SIZE);
	endfunction

	// only addresses whose header slot was written, or ones with no slot
	function automatic int unsigned pick_block_addr();
		int          r;
		int unsigned h;
		int unsigned a;
		r = $urandom_range(0, 99);
		if (r < 10 || sb.handed_out.size() == 0) begin
			return $urandom_range(0, HEADER_BYTES - 1);
		end
		if (r < 55) begin
			h = sb.handed_out[sb.handed_out.size() - 1];
		end else begin
			h = sb.handed_out[$urandom_range(0, sb.handed_out.size() - 1)];
		end
		if (r < 65) begin
			// another address in the same header slot
			a = ((h - HEADER_BYTES) / ALIGN) * ALIGN + HEADER_BYTES + $urandom_range(0, ALIGN - 1);
			if (a <= MAX_SIZE) begin
				return a;
			end
		end
		return h;
	endfunction

	function automatic int unsigned pick_restore();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50 && sb.saved_tops.size() != 0) begin
			return sb.saved_tops[$urandom_range(0, sb.saved_tops.size() - 1)];
		end
		if (r < 70) begin
			return $urandom_range(0, MAX_SIZE);
		end
		if (r < 80) begin
			return MAX_SIZE;
		end
		if (r < 90) begin
			return sb.first_offset;
		end
		return $urandom_range(0, 255);
	endfunction

	task automatic offer_random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38) begin
			offer_request(ACT_ALLOC, pick_size(), $urandom_range(0, MAX_SIZE));
		end else if (r < 58) begin
			offer_request(ACT_FREE, $urandom_range(0, MAX_SIZE), pick_block_addr());
		end else if (r < 78) begin
			offer_request(ACT_REALLOC, pick_size(), pick_block_addr());
		end else if (r < 88) begin
			offer_request(ACT_SAVE, $urandom_range(0, MAX_SIZE), $urandom_range(0, MAX_SIZE));
		end else begin
			offer_request(ACT_RESTORE, $urandom_range(0, MAX_SIZE), pick_restore());
		end
	endtask

	task automatic run_phase(int unsigned arena, int unsigned first, int count, bit calm,
			bit squeeze);
		wait_drained();
		write_reg(REG_ARENA_SIZE, arena);
		write_reg(REG_FIRST_OFFSET, first);
		quiet = calm;
		for (int i = 0; i < count; i++) begin
			// hold the output while requests keep coming
			if (squeeze && i == count / 3) begin
				want_hold = 1'b1;
			end
			offer_random_request();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_ARENA_SIZE, MAX_SIZE);
		write_reg(REG_FIRST_OFFSET, 0);
		offer_request(ACT_SAVE, 0, 0);
		offer_request(ACT_ALLOC, 0, 0);
		offer_request(ACT_ALLOC, 1, 0);
		offer_request(ACT_ALLOC, MAX_SIZE, 0);
		offer_request(ACT_FREE, 0, 0);
		offer_request(ACT_FREE, 0, 5);
		offer_request(ACT_FREE, 0, 32);
		offer_request(ACT_FREE, 0, 32);
		offer_request(ACT_REALLOC, 100, 0);
		offer_request(ACT_REALLOC, 200, 32);
		offer_request(ACT_ALLOC, 40, 0);
		offer_request(ACT_REALLOC, 10, 32);
		offer_request(ACT_REALLOC, 16, 32);
		offer_request(ACT_REALLOC, 0, 16);
		offer_request(ACT_REALLOC, MAX_SIZE, 384);
		offer_request(ACT_REALLOC, 20, 384);
		offer_request(ACT_RESTORE, 0, MAX_SIZE);
		offer_request(ACT_ALLOC, 0, 0);
		offer_request(ACT_REALLOC, 0, 32);
		offer_request(ACT_SAVE, 0, 0);
		offer_request(ACT_RESTORE, 0, 100);
		offer_request(ACT_ALLOC, 7, 0);
		offer_request(ACT_FREE, 0, 116);
		offer_request(ACT_REALLOC, 1, 3);
		offer_request(ACT_RESTORE, 0, 0);

		run_phase(MAX_SIZE, 0, 400, 1'b0, 1'b1);
		run_phase(0, 0, 40, 1'b0, 1'b0);
		run_phase(4096, 17, 250, 1'b1, 1'b0);
		run_phase(MAX_SIZE, MAX_SIZE, 60, 1'b0, 1'b0);
		run_phase(300, 65520, 50, 1'b0, 1'b0);
		run_phase($urandom_range(1024, MAX_SIZE), $urandom_range(0, 4096), 300, 1'b0, 1'b0);
		run_phase(MAX_SIZE - 1, 1, 300, 1'b1, 1'b0);

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/aba_pkg.sv
rtl/core/aba_ram.sv
rtl/core/arena_bump_allocator_top.sv
rtl/core/aba_checker.sv
sim/tb.sv
